FILE: sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package stq_pkg;
	localparam int unsigned NumTimersDef = 64;
	localparam int unsigned QueueIdBitsDef = 8;
	localparam logic [31:0] AllOnes = 32'hffff_ffff;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_INIT  = 3'd2,
		CMD_START = 3'd3,
		CMD_TICK  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		K_ALLOC   = 3'd0,
		K_NONE    = 3'd1,
		K_ACK     = 3'd2,
		K_EXPIRED = 3'd3,
		K_NOEXP   = 3'd4,
		K_REJECT  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_RUN   = 2'd2
	} status_t;
endpackage
`default_nettype wire

FILE: sv/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module stq_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Pool of timers kept in a deadline-sorted linked list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each result appears
// for one cycle with strobe high; the receiver cannot stall, so results must
// be captured on the cycle they appear. last marks the final result of a
// request. Timing: init, free, unknown commands, rejected starts and ticks
// with nothing due answer in the cycle after the request is taken; allocate
// scans status flops one slot a cycle; start walks the list through the
// deadline and link RAMs with a read state (S_SRD) and a compare state
// (S_SCMP) per visited entry, as the RAMs share a read address and register
// their read data; tick walks the due entries through S_TRD and S_TCMP and
// sends each expired timer one entry late, once the walk knows whether it is
// the final one, one expired result per due entry. State lives in RAMs
// for deadline, link, queue and payload; slot status is in flip-flops since
// reset clears it. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_timer_queue #(
	parameter int unsigned NUM_TIMERS = stq_pkg::NumTimersDef,
	parameter int unsigned QUEUE_ID_BITS = stq_pkg::QueueIdBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [5:0]  slot,
	input  wire logic [31:0] timeout,
	input  wire logic [7:0]  dest_queue,
	input  wire logic [31:0] event_data,
	output logic             strobe,
	output logic [2:0]       result_kind,
	output logic [5:0]       result_slot,
	output logic [7:0]       result_queue,
	output logic [31:0]      result_data,
	output logic [31:0]      tick_now,
	output logic             last
);
	import stq_pkg::*;

	localparam int unsigned SW = $clog2(NUM_TIMERS);
	// link width: one extra bit for the end marker
	localparam int unsigned LW = SW + 1;
	localparam logic [LW-1:0] EndMark = LW'(NUM_TIMERS);

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC, S_SRD, S_SCMP, S_TRD, S_TCMP, S_DONE
	} state_t;

	state_t state_q;
	status_t status_q [NUM_TIMERS];
	logic [LW-1:0] head_q, cur_q, prev_q, new_q;
	logic [31:0] tick_q, earliest_q, ndl_q;
	logic [SW-1:0] scan_q;
	logic [6:0] cnt_q;
	logic first_q;
	// expired timer waiting until the walk knows whether it is the final one
	logic [5:0] hold_slot_q;
	logic [7:0] hold_queue_q;
	logic [31:0] hold_data_q;

	// RAM ports
	logic dl_we, lk_we, qd_we;
	logic [SW-1:0] dl_wa, lk_wa, qd_wa, rd_a;
	logic [31:0] dl_wd, dl_rd, pl_rd;
	logic [LW-1:0] lk_wd, lk_rd;
	logic [QUEUE_ID_BITS-1:0] q_rd;

	stq_ram #(.Width(32), .Depth(NUM_TIMERS)) u_dl (
		.clk, .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(rd_a), .rdata(dl_rd));
	stq_ram #(.Width(LW), .Depth(NUM_TIMERS)) u_lk (
		.clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(rd_a), .rdata(lk_rd));
	stq_ram #(.Width(QUEUE_ID_BITS), .Depth(NUM_TIMERS)) u_qu (
		.clk, .we(qd_we), .waddr(qd_wa), .wdata(QUEUE_ID_BITS'(dest_queue)),
		.raddr(rd_a), .rdata(q_rd));
	stq_ram #(.Width(32), .Depth(NUM_TIMERS)) u_pl (
		.clk, .we(qd_we), .waddr(qd_wa), .wdata(event_data), .raddr(rd_a),
		.rdata(pl_rd));

	logic accept, in_range, cur_valid;
	assign accept = start && !busy;
	assign in_range = {1'b0, slot} < 7'(NUM_TIMERS);
	assign cur_valid = cur_q != EndMark;
	assign busy = state_q != S_IDLE;
	assign rd_a = cur_q[SW-1:0];

	// write-port control: combinational from state and the accepted request
	always_comb begin
		dl_we = 1'b0; dl_wa = slot[SW-1:0]; dl_wd = timeout + tick_q;
		lk_we = 1'b0; lk_wa = new_q[SW-1:0]; lk_wd = cur_q;
		qd_we = accept && command == CMD_INIT && in_range;
		qd_wa = slot[SW-1:0];
		if (accept && command == CMD_START && in_range && status_q[slot[SW-1:0]] != ST_RUN) begin
			dl_we = 1'b1;
		end
		if (state_q == S_SCMP && (!cur_valid || ndl_q <= dl_rd)) begin
			// link new entry to cur; predecessor handled next cycle in S_DONE
			lk_we = 1'b1;
		end
		if (state_q == S_DONE && prev_q != EndMark) begin
			lk_we = 1'b1; lk_wa = prev_q[SW-1:0]; lk_wd = new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_TIMERS; i++) status_q[i] <= ST_FREE;
			head_q <= EndMark; tick_q <= '0; earliest_q <= AllOnes;
			strobe <= 1'b0; cur_q <= EndMark; prev_q <= EndMark; new_q <= EndMark;
			scan_q <= '0; cnt_q <= '0; first_q <= 1'b0; ndl_q <= '0;
			hold_slot_q <= '0; hold_queue_q <= '0; hold_data_q <= '0;
			result_kind <= K_ACK; result_slot <= '0; result_queue <= '0;
			result_data <= '0; tick_now <= '0; last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_slot <= '0; result_queue <= '0; result_data <= '0;
						last <= 1'b1; tick_now <= tick_q;
						priority case (1'b1)
							command == CMD_ALLOC: begin
								scan_q <= '0; state_q <= S_ALLOC;
							end
							command == CMD_FREE: begin
								strobe <= 1'b1;
								if (!in_range || status_q[slot[SW-1:0]] == ST_RUN) begin
									result_kind <= K_REJECT;
								end else begin
									result_kind <= K_ACK;
									status_q[slot[SW-1:0]] <= ST_FREE;
								end
							end
							command == CMD_INIT: begin
								strobe <= 1'b1;
								result_kind <= in_range ? K_ACK : K_REJECT;
							end
							command == CMD_START: begin
								if (!in_range || status_q[slot[SW-1:0]] == ST_RUN) begin
									strobe <= 1'b1; result_kind <= K_REJECT;
								end else begin
									status_q[slot[SW-1:0]] <= ST_RUN;
									ndl_q <= timeout + tick_q;
									new_q <= {1'b0, slot[SW-1:0]};
									cur_q <= head_q; prev_q <= EndMark;
									cnt_q <= '0; state_q <= S_SRD;
								end
							end
							command == CMD_TICK: begin
								tick_q <= tick_q + 32'd1;
								tick_now <= tick_q + 32'd1;
								cnt_q <= '0; first_q <= 1'b1;
								if (earliest_q <= tick_q + 32'd1) begin
									cur_q <= head_q; state_q <= S_TRD;
								end else begin
									strobe <= 1'b1; result_kind <= K_NOEXP;
								end
							end
							default: begin
								strobe <= 1'b1; result_kind <= K_REJECT;
							end
						endcase
					end
				end
				S_ALLOC: begin
					if (status_q[scan_q] == ST_FREE) begin
						status_q[scan_q] <= ST_ALLOC;
						strobe <= 1'b1; result_kind <= K_ALLOC;
						result_slot <= 6'(scan_q); state_q <= S_IDLE;
					end else if (32'(scan_q) == NUM_TIMERS - 1) begin
						strobe <= 1'b1; result_kind <= K_NONE; state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_SRD: state_q <= S_SCMP; // RAM read of cur in flight
				S_SCMP: begin
					if (!cur_valid || ndl_q <= dl_rd || 32'(cnt_q) >= NUM_TIMERS) begin
						state_q <= S_DONE;
					end else begin
						prev_q <= cur_q; cur_q <= lk_rd;
						cnt_q <= cnt_q + 7'd1; state_q <= S_SRD;
					end
				end
				S_DONE: begin
					if (prev_q == EndMark) begin
						head_q <= new_q; earliest_q <= ndl_q;
					end
					strobe <= 1'b1; result_kind <= K_ACK; state_q <= S_IDLE;
				end
				S_TRD: begin
					if (!cur_valid) begin
						// list ran out: the held timer, if any, is the final one
						head_q <= EndMark; earliest_q <= AllOnes;
						state_q <= S_IDLE;
						strobe <= 1'b1; last <= 1'b1;
						if (first_q) begin
							result_kind <= K_NOEXP;
						end else begin
							result_kind <= K_EXPIRED; result_slot <= hold_slot_q;
							result_queue <= hold_queue_q; result_data <= hold_data_q;
						end
					end else begin
						state_q <= S_TCMP;
					end
				end
				S_TCMP: begin
					if (dl_rd <= tick_q && 32'(cnt_q) < NUM_TIMERS) begin
						status_q[cur_q[SW-1:0]] <= ST_ALLOC;
						// another due entry follows the held one: send it, not last
						if (!first_q) begin
							strobe <= 1'b1; result_kind <= K_EXPIRED;
							result_slot <= hold_slot_q; result_queue <= hold_queue_q;
							result_data <= hold_data_q; last <= 1'b0;
						end
						hold_slot_q <= 6'(cur_q[SW-1:0]);
						hold_queue_q <= 8'(q_rd); hold_data_q <= pl_rd;
						first_q <= 1'b0; cnt_q <= cnt_q + 7'd1;
						cur_q <= lk_rd; state_q <= S_TRD;
					end else begin
						// first not-due entry becomes the new head
						head_q <= cur_q; earliest_q <= dl_rd; state_q <= S_IDLE;
						strobe <= 1'b1; last <= 1'b1;
						if (first_q) begin
							result_kind <= K_NOEXP;
						end else begin
							result_kind <= K_EXPIRED; result_slot <= hold_slot_q;
							result_queue <= hold_queue_q; result_data <= hold_data_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy || strobe)
		else $error("request produced neither work nor result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == EndMark) |-> (earliest_q == AllOnes))
		else $error("empty list with finite earliest deadline");
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last && state_q != S_TRD && state_q != S_TCMP) |-> !busy)
		else $error("final result while still busy");
endmodule
`default_nettype wire
